>>> hdl/ogcu_pkg.sv
// shared types, constants and inflation mask table for the occupancy grid cell update
`timescale 1ns / 1ps
`default_nettype none

package ogcu_pkg;

	// map geometry and mask radius
	localparam int MAP_WIDTH   = 256;
	localparam int MAP_HEIGHT  = 256;
	localparam int MASK_RADIUS = 3;

	// only columns and rows 0..255 are addressable
	localparam int GRID_W = (MAP_WIDTH < 256) ? MAP_WIDTH : 256;
	localparam int GRID_H = (MAP_HEIGHT < 256) ? MAP_HEIGHT : 256;

	localparam int COORD_W    = 8;
	localparam int ADDR_W     = 2 * COORD_W;
	localparam int CELLS      = 1 << ADDR_W;
	localparam int NB_W       = COORD_W + 2;
	localparam int LO_W       = 16;
	localparam int SUM_W      = LO_W + 1;
	localparam int LIMIT_W    = 15;
	localparam int CNT_W      = 6;
	localparam int MASK_SLOTS = 64;
	localparam int OFF_W      = 4;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// register reset values
	localparam logic signed [LO_W-1:0]    RST_HIT_INC  = 16'sd218;
	localparam logic signed [LO_W-1:0]    RST_MISS_INC = -16'sd102;
	localparam logic        [LIMIT_W-1:0] RST_CLAMP    = 15'd2560;
	localparam logic        [LIMIT_W-1:0] RST_THRESH   = 15'd512;

	typedef enum logic [1:0] {
		REG_HIT_INC  = 2'd0,
		REG_MISS_INC = 2'd1,
		REG_CLAMP    = 2'd2,
		REG_THRESH   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_UNKNOWN  = 2'd0,
		CLS_EMPTY    = 2'd1,
		CLS_OCCUPIED = 2'd2,
		CLS_INFLATED = 2'd3
	} cell_class_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_CENTER,
		ST_WALK,
		ST_DRAIN,
		ST_FLUSH
	} ogcu_state_t;

	typedef struct packed {
		logic signed [LO_W-1:0]    hit_inc;
		logic signed [LO_W-1:0]    miss_inc;
		logic        [LIMIT_W-1:0] clamp_limit;
		logic        [LIMIT_W-1:0] threshold;
	} ogcu_cfg_t;

	// one stored cell: log-odds, inflation count, center mark
	typedef struct packed {
		logic signed [LO_W-1:0]  lval;
		logic        [CNT_W-1:0] count;
		logic                    center;
	} cell_word_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		cell_word_t        data;
	} ogcu_wr_t;

	function automatic int mask_count();
		int n;
		n = 0;
		for (int x = 0; x < MASK_RADIUS; x++) begin
			for (int y = 0; y < MASK_RADIUS; y++) begin
				if (!(x == 0 && y == 0) && (x * x + y * y <= MASK_RADIUS * MASK_RADIUS)
						&& (n + 4 <= MASK_SLOTS)) begin
					if (x != 0) n++;
					if (y != 0) n++;
					if (x != 0 && y != 0) n++;
					n++;
				end
			end
		end
		return n;
	endfunction

	localparam int MASK_N     = mask_count();
	localparam int MASK_DEPTH = (MASK_N > 0) ? MASK_N : 1;
	localparam int IDX_W      = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;

	typedef struct packed {
		logic signed [OFF_W-1:0] dx;
		logic signed [OFF_W-1:0] dy;
	} mask_off_t;

	typedef mask_off_t [MASK_DEPTH-1:0] mask_tab_t;

	// mask order: x outer, y inner, mirrored offsets before the positive one
	function automatic mask_tab_t build_mask();
		mask_tab_t tab;
		int n;
		tab = '0;
		n = 0;
		for (int x = 0; x < MASK_RADIUS; x++) begin
			for (int y = 0; y < MASK_RADIUS; y++) begin
				if (!(x == 0 && y == 0) && (x * x + y * y <= MASK_RADIUS * MASK_RADIUS)
						&& (n + 4 <= MASK_SLOTS)) begin
					if (x != 0) begin
						tab[n].dx = OFF_W'(-x);
						tab[n].dy = OFF_W'(y);
						n++;
					end
					if (y != 0) begin
						tab[n].dx = OFF_W'(x);
						tab[n].dy = OFF_W'(-y);
						n++;
					end
					if (x != 0 && y != 0) begin
						tab[n].dx = OFF_W'(-x);
						tab[n].dy = OFF_W'(-y);
						n++;
					end
					tab[n].dx = OFF_W'(x);
					tab[n].dy = OFF_W'(y);
					n++;
				end
			end
		end
		return tab;
	endfunction

	localparam mask_tab_t         MASK_TAB = build_mask();
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MASK_DEPTH - 1);

	function automatic cell_class_t class_of(
		logic signed [LO_W-1:0]    lo,
		logic        [CNT_W-1:0]   cnt,
		logic        [LIMIT_W-1:0] thr
	);
		logic signed [LO_W-1:0] t;
		cell_class_t cls;
		t = $signed({1'b0, thr});
		if (lo > t) begin
			cls = CLS_OCCUPIED;
		end else if (cnt != '0) begin
			cls = CLS_INFLATED;
		end else if (lo < -t) begin
			cls = CLS_EMPTY;
		end else begin
			cls = CLS_UNKNOWN;
		end
		return cls;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ogcu_cell_ram.sv
// single-port-read single-port-write cell memory, registered read
`timescale 1ns / 1ps
`default_nettype none

module ogcu_cell_ram (
	input  wire                                clk,
	input  wire                                rd_en,
	input  wire  [ogcu_pkg::ADDR_W-1:0]        rd_addr,
	output ogcu_pkg::cell_word_t               rd_data,
	input  wire  ogcu_pkg::ogcu_wr_t           wr
);

	ogcu_pkg::cell_word_t mem [ogcu_pkg::CELLS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/ogcu_cfg_regs.sv
// apb configuration registers: increments, clamp limit, threshold
`timescale 1ns / 1ps
`default_nettype none

module ogcu_cfg_regs (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [ogcu_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire  [ogcu_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ogcu_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output ogcu_pkg::ogcu_cfg_t                  cfg
);

	ogcu_pkg::ogcu_cfg_t cfg_q;
	ogcu_pkg::reg_idx_t  idx;
	logic                wr_req;

	assign idx    = ogcu_pkg::reg_idx_t'(paddr[ogcu_pkg::APB_ADDR_W-1:2]);
	assign wr_req = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_inc     <= ogcu_pkg::RST_HIT_INC;
			cfg_q.miss_inc    <= ogcu_pkg::RST_MISS_INC;
			cfg_q.clamp_limit <= ogcu_pkg::RST_CLAMP;
			cfg_q.threshold   <= ogcu_pkg::RST_THRESH;
		end else if (wr_req) begin
			case (idx)
				ogcu_pkg::REG_HIT_INC:  cfg_q.hit_inc     <= pwdata[ogcu_pkg::LO_W-1:0];
				ogcu_pkg::REG_MISS_INC: cfg_q.miss_inc    <= pwdata[ogcu_pkg::LO_W-1:0];
				ogcu_pkg::REG_CLAMP:    cfg_q.clamp_limit <= pwdata[ogcu_pkg::LIMIT_W-1:0];
				ogcu_pkg::REG_THRESH:   cfg_q.threshold   <= pwdata[ogcu_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// signed registers read back sign extended
	always_comb begin
		case (idx)
			ogcu_pkg::REG_HIT_INC: prdata = {
				{(ogcu_pkg::APB_DATA_W - ogcu_pkg::LO_W){cfg_q.hit_inc[ogcu_pkg::LO_W-1]}},
				cfg_q.hit_inc};
			ogcu_pkg::REG_MISS_INC: prdata = {
				{(ogcu_pkg::APB_DATA_W - ogcu_pkg::LO_W){cfg_q.miss_inc[ogcu_pkg::LO_W-1]}},
				cfg_q.miss_inc};
			ogcu_pkg::REG_CLAMP: prdata = {
				{(ogcu_pkg::APB_DATA_W - ogcu_pkg::LIMIT_W){1'b0}}, cfg_q.clamp_limit};
			ogcu_pkg::REG_THRESH: prdata = {
				{(ogcu_pkg::APB_DATA_W - ogcu_pkg::LIMIT_W){1'b0}}, cfg_q.threshold};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/occupancy_grid_cell_update.sv
// top level: occupancy grid log-odds update with inflation mask walk
//
//   channel   handshake                      payload
//   request   start, busy (accept: start&!busy)  cell_x, cell_y, hit
//   result    result_valid (one cycle strobe)    out_x, out_y, cell_class, last
//   config    apb psel/penable/pwrite/pready     paddr, pwdata, prdata
//
// sequence: a request outside the map keeps busy high for the flush state only; a
//   request with no threshold crossing passes through add/clamp, write back and flush
// a crossing adds a walk step per mask entry (MASK_N, 24 at radius 3) and a drain
//   state before the flush; the single read port of the cell memory
//   sets the pace of one neighbor per cycle
// reset: a clearing pass writes all 65536 cells to zero while busy stays high;
//   configuration writes are taken during it
// the receiver cannot stall: each result waits in a pending register until the next
//   one or the flush, so that the final one carries last
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_cell_update (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// request
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [ogcu_pkg::COORD_W-1:0]         cell_x,
	input  wire  [ogcu_pkg::COORD_W-1:0]         cell_y,
	input  wire                                  hit,
	// result
	output logic                                 result_valid,
	output logic [ogcu_pkg::COORD_W-1:0]         out_x,
	output logic [ogcu_pkg::COORD_W-1:0]         out_y,
	output logic [1:0]                           cell_class,
	output logic                                 last,
	// configuration
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [ogcu_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire  [ogcu_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ogcu_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	ogcu_pkg::ogcu_cfg_t   cfg;
	ogcu_pkg::ogcu_state_t state_q, state_d;

	// memory ports
	logic                          rd_en;
	logic [ogcu_pkg::ADDR_W-1:0]   rd_addr;
	ogcu_pkg::cell_word_t          rd_word;
	ogcu_pkg::ogcu_wr_t            wr;

	logic [ogcu_pkg::ADDR_W-1:0]   clear_addr_q;

	// request registers
	logic [ogcu_pkg::COORD_W-1:0]  x_q, y_q;
	logic                          hit_q;

	// center update
	ogcu_pkg::cell_word_t          old_word_q;
	logic signed [ogcu_pkg::LO_W-1:0] new_lo_q;
	logic                          inc_q, dec_q;

	// mask walk
	logic [ogcu_pkg::IDX_W-1:0]    idx_q;
	logic                          nb_valid_s1;
	logic [ogcu_pkg::COORD_W-1:0]  nb_x_s1, nb_y_s1;

	// pending and output result
	logic [ogcu_pkg::COORD_W-1:0]  pend_x_q, pend_y_q;
	ogcu_pkg::cell_class_t         pend_cls_q;
	logic                          res_valid_q, last_q;
	logic [ogcu_pkg::COORD_W-1:0]  out_x_q, out_y_q;
	ogcu_pkg::cell_class_t         out_cls_q;

	// combinational
	logic                          accept, in_map;
	logic signed [ogcu_pkg::LO_W-1:0]  incr;
	logic signed [ogcu_pkg::SUM_W-1:0] sum, pos_lim, neg_lim, clamped;
	logic signed [ogcu_pkg::LO_W-1:0]  thr;
	logic                          up, down, set_center, clr_center;
	ogcu_pkg::mask_off_t           off;
	logic [ogcu_pkg::NB_W-1:0]     nx, ny;
	logic                          nb_in;
	logic [ogcu_pkg::CNT_W-1:0]    new_cnt;
	logic                          pend_load, emit_en, emit_last;
	logic [ogcu_pkg::COORD_W-1:0]  pend_x_d, pend_y_d;
	ogcu_pkg::cell_class_t         pend_cls_d;

	ogcu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ogcu_cell_ram u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word),
		.wr      (wr)
	);

	assign busy   = (state_q != ogcu_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign in_map = ({1'b0, cell_x} < (ogcu_pkg::COORD_W + 1)'(ogcu_pkg::GRID_W))
		&& ({1'b0, cell_y} < (ogcu_pkg::COORD_W + 1)'(ogcu_pkg::GRID_H));

	// add and clamp, from the center cell just read
	assign incr    = hit_q ? cfg.hit_inc : cfg.miss_inc;
	assign sum     = {rd_word.lval[ogcu_pkg::LO_W-1], rd_word.lval}
		+ {incr[ogcu_pkg::LO_W-1], incr};
	assign pos_lim = $signed({2'b00, cfg.clamp_limit});
	assign neg_lim = -pos_lim;
	assign clamped = (sum > pos_lim) ? pos_lim : ((sum < neg_lim) ? neg_lim : sum);

	// strict threshold crossing decides mark or unmark of the center
	assign thr        = $signed({1'b0, cfg.threshold});
	assign up         = (old_word_q.lval < thr) && (new_lo_q > thr);
	assign down       = (old_word_q.lval > thr) && (new_lo_q < thr);
	assign set_center = up && !old_word_q.center;
	assign clr_center = down && old_word_q.center;

	// neighbor coordinates for the current mask entry
	assign off   = ogcu_pkg::MASK_TAB[idx_q];
	assign nx    = {2'b00, x_q} + {{(ogcu_pkg::NB_W - ogcu_pkg::OFF_W){off.dx[ogcu_pkg::OFF_W-1]}},
		off.dx};
	assign ny    = {2'b00, y_q} + {{(ogcu_pkg::NB_W - ogcu_pkg::OFF_W){off.dy[ogcu_pkg::OFF_W-1]}},
		off.dy};
	assign nb_in = !nx[ogcu_pkg::NB_W-1] && !ny[ogcu_pkg::NB_W-1]
		&& (nx < ogcu_pkg::NB_W'(ogcu_pkg::GRID_W))
		&& (ny < ogcu_pkg::NB_W'(ogcu_pkg::GRID_H));

	// saturating inflation count
	always_comb begin
		if (inc_q && (rd_word.count != ogcu_pkg::CNT_MAX)) begin
			new_cnt = rd_word.count + 1'b1;
		end else if (dec_q && (rd_word.count != '0)) begin
			new_cnt = rd_word.count - 1'b1;
		end else begin
			new_cnt = rd_word.count;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ogcu_pkg::ST_CLEAR: begin
				if (clear_addr_q == '1) state_d = ogcu_pkg::ST_IDLE;
			end
			ogcu_pkg::ST_IDLE: begin
				if (accept) state_d = in_map ? ogcu_pkg::ST_ADD : ogcu_pkg::ST_FLUSH;
			end
			ogcu_pkg::ST_ADD: begin
				state_d = ogcu_pkg::ST_CENTER;
			end
			ogcu_pkg::ST_CENTER: begin
				if ((up || down) && (ogcu_pkg::MASK_N > 0)) begin
					state_d = ogcu_pkg::ST_WALK;
				end else begin
					state_d = ogcu_pkg::ST_FLUSH;
				end
			end
			ogcu_pkg::ST_WALK: begin
				if (idx_q == ogcu_pkg::IDX_LAST) state_d = ogcu_pkg::ST_DRAIN;
			end
			ogcu_pkg::ST_DRAIN: begin
				state_d = ogcu_pkg::ST_FLUSH;
			end
			ogcu_pkg::ST_FLUSH: begin
				state_d = ogcu_pkg::ST_IDLE;
			end
			default: state_d = ogcu_pkg::ST_IDLE;
		endcase
	end

	// memory control and result selection
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr         = '0;
		pend_load  = 1'b0;
		pend_x_d   = x_q;
		pend_y_d   = y_q;
		pend_cls_d = ogcu_pkg::CLS_UNKNOWN;
		emit_en    = 1'b0;
		emit_last  = 1'b0;
		case (state_q)
			ogcu_pkg::ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = clear_addr_q;
			end
			ogcu_pkg::ST_IDLE: begin
				if (accept && in_map) begin
					rd_en   = 1'b1;
					rd_addr = {cell_y, cell_x};
				end
				if (accept && !in_map) begin
					pend_load  = 1'b1;
					pend_x_d   = cell_x;
					pend_y_d   = cell_y;
					pend_cls_d = ogcu_pkg::CLS_UNKNOWN;
				end
			end
			ogcu_pkg::ST_CENTER: begin
				wr.en            = 1'b1;
				wr.addr          = {y_q, x_q};
				wr.data.lval     = new_lo_q;
				wr.data.count    = old_word_q.count;
				wr.data.center   = set_center ? 1'b1 : (clr_center ? 1'b0 : old_word_q.center);
				pend_load        = 1'b1;
				pend_cls_d       = ogcu_pkg::class_of(new_lo_q, old_word_q.count, cfg.threshold);
			end
			ogcu_pkg::ST_WALK, ogcu_pkg::ST_DRAIN: begin
				if (state_q == ogcu_pkg::ST_WALK && nb_in) begin
					rd_en   = 1'b1;
					rd_addr = {ny[ogcu_pkg::COORD_W-1:0], nx[ogcu_pkg::COORD_W-1:0]};
				end
				// write back the neighbor read in the previous cycle
				if (nb_valid_s1) begin
					wr.en            = 1'b1;
					wr.addr          = {nb_y_s1, nb_x_s1};
					wr.data.lval     = rd_word.lval;
					wr.data.count    = new_cnt;
					wr.data.center   = rd_word.center;
					emit_en          = 1'b1;
					pend_load        = 1'b1;
					pend_x_d         = nb_x_s1;
					pend_y_d         = nb_y_s1;
					pend_cls_d       = ogcu_pkg::class_of(rd_word.lval, new_cnt,
						cfg.threshold);
				end
			end
			ogcu_pkg::ST_FLUSH: begin
				emit_en   = 1'b1;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ogcu_pkg::ST_CLEAR;
			clear_addr_q <= '0;
			inc_q        <= 1'b0;
			dec_q        <= 1'b0;
			idx_q        <= '0;
			nb_valid_s1  <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit_en;
			if (state_q == ogcu_pkg::ST_CLEAR) begin
				clear_addr_q <= clear_addr_q + 1'b1;
			end
			if (state_q == ogcu_pkg::ST_CENTER) begin
				inc_q <= set_center;
				dec_q <= clr_center;
			end
			if (state_q == ogcu_pkg::ST_WALK) begin
				idx_q       <= (idx_q == ogcu_pkg::IDX_LAST) ? '0 : idx_q + 1'b1;
				nb_valid_s1 <= nb_in;
			end else begin
				idx_q       <= '0;
				nb_valid_s1 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= cell_x;
			y_q   <= cell_y;
			hit_q <= hit;
		end
		if (state_q == ogcu_pkg::ST_ADD) begin
			old_word_q <= rd_word;
			new_lo_q   <= clamped[ogcu_pkg::LO_W-1:0];
		end
		if (state_q == ogcu_pkg::ST_WALK) begin
			nb_x_s1 <= nx[ogcu_pkg::COORD_W-1:0];
			nb_y_s1 <= ny[ogcu_pkg::COORD_W-1:0];
		end
		if (emit_en) begin
			out_x_q   <= pend_x_q;
			out_y_q   <= pend_y_q;
			out_cls_q <= pend_cls_q;
			last_q    <= emit_last;
		end
		if (pend_load) begin
			pend_x_q   <= pend_x_d;
			pend_y_q   <= pend_y_d;
			pend_cls_q <= pend_cls_d;
		end
	end

	assign result_valid = res_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign cell_class   = out_cls_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_nb_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		nb_valid_s1 |-> (state_q == ogcu_pkg::ST_WALK || state_q == ogcu_pkg::ST_DRAIN))
		else $error("neighbor stage valid outside the mask walk");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && last_q) |-> (state_q == ogcu_pkg::ST_IDLE))
		else $error("final result shown while the block is still busy");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q != ogcu_pkg::ST_IDLE))
		else $error("cell memory written while idle");

	a_cnt_no_wrap_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && nb_valid_s1 && inc_q) |-> (wr.data.count >= rd_word.count))
		else $error("inflation count wrapped on increment");

	a_cnt_no_wrap_down: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && nb_valid_s1 && dec_q) |-> (wr.data.count <= rd_word.count))
		else $error("inflation count wrapped on decrement");
`endif

endmodule

`default_nettype wire
